>>> hdl/bmap_pkg.sv
`timescale 1ns / 1ps
package bmap_pkg;
  localparam int MaxLeft = 16;
  localparam int MaxRight = 16;
  localparam int MaxDegree = 8;
  localparam int LW = $clog2(MaxLeft);
  localparam int RW = $clog2(MaxRight);
  localparam int DW = $clog2(MaxDegree);
  localparam int DCW = $clog2(MaxDegree + 1);
  localparam int SW = $clog2(MaxLeft + 1);

  localparam logic [0:0] CfgLeft = 1'b0;
  localparam logic [0:0] CfgRight = 1'b1;

  typedef enum logic [3:0] {
    OpNone, OpLoad, OpClearPartners, OpRootInit, OpFetch, OpDecide,
    OpCommit, OpReport, OpClearGraph
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic search_done;
    logic commit_done;
    logic roots_done;
    logic report_done;
    logic report_empty;
  } status_t;
endpackage

>>> hdl/bipartite_matching_augmenting_path_core.sv
`timescale 1ns / 1ps
// Edge transactions are accepted one per cycle while idle and never raise busy.
// A finish transaction clears partners, then keeps busy high while each searched left
// vertex is made a root and searched in fetch and decide steps, a successful search
// commits its rematched vertices, right_count results go out and the graph is cleared.
// The receiver cannot stall; each result is on strobe for one cycle, one per cycle.
// Synchronous active-high reset clears degrees, partners, flags and restores counts to 16.
module bipartite_matching_augmenting_path_core
  import bmap_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic       kind,
  input  logic [3:0] left_vertex,
  input  logic [3:0] right_vertex,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [4:0] cfg_data,
  output logic       strobe,
  output logic [3:0] right_index,
  output logic       is_matched,
  output logic [3:0] partner,
  output logic [4:0] match_total,
  output logic       edge_overflow,
  output logic       last
);
  cmd_t cmd;
  status_t stat;
  assign cfg_ready = 1'b1;

  bmap_ctrl u_ctrl (.clk, .rst, .start, .kind, .busy, .cmd, .stat);
  bmap_datapath u_dp (
    .clk, .rst, .cmd, .stat, .left_vertex, .right_vertex,
    .cfg_valid, .cfg_index(cfg_index[0]), .cfg_index_ok(cfg_index[1] == 1'b0),
    .cfg_data, .result_valid(strobe), .right_index, .is_matched, .partner,
    .match_total, .edge_overflow, .last
  );
endmodule

>>> hdl/bmap_ctrl.sv
`timescale 1ns / 1ps
module bmap_ctrl
  import bmap_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  logic    kind,
  output logic    busy,
  output cmd_t    cmd,
  input  status_t stat
);
  typedef enum logic [2:0] {
    SIdle, SClear, SRoot, SFetch, SDecide, SCommit, SReport, SWipe
  } state_t;
  state_t state;

  always_comb begin
    busy = (state != SIdle);
    unique case (state)
      SIdle:   cmd.op = (start && !kind) ? OpLoad : (start ? OpClearPartners : OpNone);
      SClear:  cmd.op = OpRootInit;
      SRoot:   cmd.op = OpRootInit;
      SFetch:  cmd.op = OpFetch;
      SDecide: cmd.op = OpDecide;
      SCommit: cmd.op = OpCommit;
      SReport: cmd.op = OpReport;
      SWipe:   cmd.op = OpClearGraph;
      default: cmd.op = OpNone;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SIdle;
    end else begin
      unique case (state)
        SIdle: if (start && kind) state <= SRoot;
        SClear: state <= SRoot;
        SRoot: state <= stat.roots_done ? (stat.report_empty ? SWipe : SReport) : SFetch;
        SFetch: state <= SDecide;
        SDecide: priority if (stat.commit_done) state <= SCommit;
          else if (stat.search_done) state <= SRoot;
          else state <= SFetch;
        SCommit: if (stat.search_done) state <= SRoot;
        SReport: if (stat.report_done) state <= SWipe;
        SWipe: state <= SIdle;
        default: state <= SIdle;
      endcase
    end
  end
endmodule

>>> hdl/bmap_datapath.sv
`timescale 1ns / 1ps
module bmap_datapath
  import bmap_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output status_t     stat,
  input  logic [3:0]  left_vertex,
  input  logic [3:0]  right_vertex,
  input  logic        cfg_valid,
  input  logic        cfg_index,
  input  logic        cfg_index_ok,
  input  logic [4:0]  cfg_data,
  output logic        result_valid,
  output logic [3:0]  right_index,
  output logic        is_matched,
  output logic [3:0]  partner,
  output logic [4:0]  match_total,
  output logic        edge_overflow,
  output logic        last
);
  logic [RW-1:0]  adj [MaxLeft*MaxDegree];
  logic [RW-1:0]  adj_q;
  logic [DCW-1:0] deg [MaxLeft];
  logic [MaxRight-1:0] pvalid;
  logic [LW-1:0]  pstore [MaxRight];
  logic [MaxLeft-1:0] visited;
  logic [LW-1:0]  stk_v [MaxLeft];
  logic [DW:0]    stk_p [MaxLeft];
  logic [SW-1:0]  depth;
  logic [SW-1:0]  root;
  logic [4:0]     tally;
  logic           ovf;
  logic [4:0]     lcount, rcount;
  logic [4:0]     ridx;
  logic           hit;
  logic           exhausted;
  logic [SW-1:0]  lc_sat;
  logic [4:0]     rc_sat;
  logic [LW-1:0]  top_v;
  logic [DW:0]    top_p;
  logic [LW-1:0]  w;

  assign lc_sat = (lcount > 5'(MaxLeft)) ? SW'(MaxLeft) : SW'(lcount);
  assign rc_sat = (rcount > 5'(MaxRight)) ? 5'(MaxRight) : rcount;
  assign top_v = stk_v[LW'(depth - 1'b1)];
  assign top_p = stk_p[LW'(depth - 1'b1)];
  assign w = pstore[adj_q];
  assign exhausted = (top_p >= (DW+1)'(deg[top_v]));
  assign hit = (depth != '0) && !exhausted && !pvalid[adj_q];

  assign stat.roots_done = (root >= lc_sat);
  assign stat.report_empty = (rc_sat == 5'd0);
  assign stat.report_done = (ridx + 5'd1 >= rc_sat);
  assign stat.commit_done = hit && (depth > SW'(1));
  assign stat.search_done = (cmd.op == OpCommit) ? (depth <= SW'(2)) :
                            ((depth == '0) || ((depth == SW'(1)) && (hit || exhausted)));

  always_ff @(posedge clk) begin
    if (cmd.op == OpFetch && top_p < (DW+1)'(deg[top_v]))
      adj_q <= adj[{top_v, top_p[DW-1:0]}];
    else if (cmd.op == OpDecide && stat.commit_done)
      adj_q <= adj[{stk_v[LW'(depth - 2'd2)], stk_p[LW'(depth - 2'd2)][DW-1:0]}];
    else if (cmd.op == OpCommit && depth > SW'(2))
      adj_q <= adj[{stk_v[LW'(depth - 2'd3)], stk_p[LW'(depth - 2'd3)][DW-1:0]}];
    if (cmd.op == OpLoad && deg[left_vertex] < DCW'(MaxDegree))
      adj[{left_vertex, deg[left_vertex][DW-1:0]}] <= right_vertex;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MaxLeft; i++) deg[i] <= '0;
      pvalid <= '0; visited <= '0; tally <= '0; ovf <= 1'b0;
      lcount <= 5'd16; rcount <= 5'd16; depth <= '0; root <= '0;
      ridx <= '0; result_valid <= 1'b0;
    end else begin
      result_valid <= (cmd.op == OpReport);
      if (cfg_valid && cfg_index_ok) begin
        if (cfg_index == CfgLeft) lcount <= cfg_data;
        else rcount <= cfg_data;
      end
      unique case (cmd.op)
        OpLoad: begin
          if (deg[left_vertex] < DCW'(MaxDegree)) deg[left_vertex] <= deg[left_vertex] + 1'b1;
          else ovf <= 1'b1;
        end
        OpClearPartners: begin
          pvalid <= '0; tally <= '0; root <= '0; depth <= '0; ridx <= '0;
          for (int i = 0; i < MaxRight; i++) pstore[i] <= '0;
        end
        OpRootInit: begin
          if (root < lc_sat) begin
            visited <= MaxLeft'(1'b1) << root;
            stk_v[0] <= LW'(root); stk_p[0] <= '0;
            depth <= SW'(1);
            root <= root + 1'b1;
          end
        end
        OpFetch: ;
        OpDecide: begin
          if (exhausted) begin
            depth <= depth - 1'b1;
            if (depth > SW'(1)) stk_p[LW'(depth - 2'd2)] <= stk_p[LW'(depth - 2'd2)] + 1'b1;
          end else if (hit) begin
            pvalid[adj_q] <= 1'b1; pstore[adj_q] <= top_v;
            tally <= tally + 1'b1;
          end else if (visited[w] || depth >= SW'(MaxLeft)) begin
            stk_p[LW'(depth - 1'b1)] <= top_p + 1'b1;
          end else begin
            visited[w] <= 1'b1;
            stk_v[LW'(depth)] <= w; stk_p[LW'(depth)] <= '0;
            depth <= depth + 1'b1;
          end
        end
        OpCommit: begin
          depth <= depth - 1'b1;
          pvalid[adj_q] <= 1'b1;
          pstore[adj_q] <= stk_v[LW'(depth - 2'd2)];
        end
        OpReport: begin
          right_index <= ridx[3:0];
          is_matched <= pvalid[ridx[RW-1:0]];
          partner <= pvalid[ridx[RW-1:0]] ? 4'(pstore[ridx[RW-1:0]]) : 4'd0;
          match_total <= tally;
          edge_overflow <= ovf;
          last <= stat.report_done;
          ridx <= ridx + 5'd1;
        end
        OpClearGraph: begin
          for (int i = 0; i < MaxLeft; i++) deg[i] <= '0;
          ovf <= 1'b0;
        end
        default: ;
      endcase
    end
  end
endmodule
